[hw/rtl/ffcu_pkg.sv]
// ----------------------------------------------------------------------------
// ffcu_pkg
// Shared constants for the flash command unit: bus kinds, command codes,
// status bits, identifier bytes and default geometry.
// ----------------------------------------------------------------------------
package ffcu_pkg;

    localparam int ADDR_BITS_DEF  = 20;
    localparam int BLOCK_BITS_DEF = 16;

    localparam int ADDR_W = 20;
    localparam int DATA_W = 8;
    localparam int KIND_W = 2;
    localparam int TPB_W  = 16;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // command codes
    localparam logic [DATA_W-1:0] CMD_READ_ARRAY  = 8'hFF;
    localparam logic [DATA_W-1:0] CMD_READ_ID     = 8'h90;
    localparam logic [DATA_W-1:0] CMD_READ_STATUS = 8'h70;
    localparam logic [DATA_W-1:0] CMD_CLEAR_STAT  = 8'h50;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP = 8'h20;
    localparam logic [DATA_W-1:0] CMD_SUSPEND     = 8'hB0;
    localparam logic [DATA_W-1:0] CMD_PROGRAM     = 8'h40;
    localparam logic [DATA_W-1:0] CMD_PROGRAM_ALT = 8'h10;
    localparam logic [DATA_W-1:0] CMD_CONFIRM     = 8'hD0;

    // status bits
    localparam logic [DATA_W-1:0] ST_READY     = 8'h80;
    localparam logic [DATA_W-1:0] ST_SUSPENDED = 8'h40;
    localparam logic [DATA_W-1:0] ST_BUSY      = 8'h00;

    // identifier bytes and fixed data values
    localparam logic [DATA_W-1:0] ID_MANUFACTURER = 8'h89;
    localparam logic [DATA_W-1:0] ID_DEVICE       = 8'hA2;
    localparam logic [DATA_W-1:0] BYTE_ERASED     = 8'hFF;
    localparam logic [DATA_W-1:0] BYTE_POWER_UP   = 8'h80;

    localparam logic [TPB_W-1:0] TPB_RESET = 16'd1;

endpackage

[hw/rtl/flash_file_memory_command_unit.sv]
// ----------------------------------------------------------------------------
// flash_file_memory_command_unit
// Byte-wide flash array with a command interface, block erase with
// suspend/resume, and a tick-driven erase timer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | s_kind, s_address, s_write_data
//  m_       | out       | m_valid / m_ready  | m_read_data
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_data (ticks per erased byte)
//
//  One transaction per cycle while s_ready is high; a read result appears
//  the cycle after accept. A two-entry output (result + skid) lets
//  transactions continue while a result waits; outside the clearing pass
//  s_ready drops only when both are full. After reset a clearing pass
//  writes 0x80 to every byte with s_ready low; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
module flash_file_memory_command_unit #(
    parameter int ADDR_BITS  = ffcu_pkg::ADDR_BITS_DEF,
    parameter int BLOCK_BITS = ffcu_pkg::BLOCK_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ffcu_pkg::KIND_W-1:0] s_kind,
    input  logic [ffcu_pkg::ADDR_W-1:0] s_address,
    input  logic [ffcu_pkg::DATA_W-1:0] s_write_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ffcu_pkg::DATA_W-1:0] m_read_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ffcu_pkg::TPB_W-1:0]  cfg_data
);
    import ffcu_pkg::*;

    localparam int IDX_BITS = ADDR_BITS - BLOCK_BITS;
    localparam int DEPTH    = 1 << ADDR_BITS;

    typedef enum logic [1:0] {
        PH_NONE      = 2'd0,
        PH_SETUP     = 2'd1,
        PH_SUSPENDED = 2'd2,
        PH_ERASING   = 2'd3
    } phase_t;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] mem_rdata_reg;

    logic [TPB_W-1:0]    tpb_reg;
    logic [DATA_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0]   cmd_reg, cmd_next;
    logic                pending_reg, pending_next;
    phase_t              phase_reg, phase_next;
    logic [IDX_BITS-1:0] blk_reg, blk_next;
    logic [BLOCK_BITS:0] prog_reg, prog_next;
    logic [TPB_W-1:0]    tick_reg, tick_next;

    logic                 clr_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    // output: slot A follows the RAM read, skid holds an older result
    logic              a_valid_reg;
    logic              a_sel_array_reg;
    logic [DATA_W-1:0] a_const_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic [DATA_W-1:0] a_data;

    logic                 acc, rd_load, m_fire;
    logic [ADDR_BITS-1:0] in_addr;
    logic                 rd_sel_array;
    logic [DATA_W-1:0]    rd_const;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_wa;
    logic [DATA_W-1:0]    mem_wd;
    logic [TPB_W-1:0]     limit;
    logic [TPB_W:0]       tick_inc;
    logic [BLOCK_BITS:0]  prog_upd;

    assign in_addr   = ADDR_BITS'(s_address);
    assign s_ready   = !clr_reg && !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign acc       = s_valid && s_ready;
    assign rd_load   = acc && (s_kind == KIND_READ);
    assign m_valid   = a_valid_reg || skid_valid_reg;
    assign m_fire    = m_valid && m_ready;
    assign a_data    = a_sel_array_reg ? mem_rdata_reg : a_const_reg;
    assign m_read_data = skid_valid_reg ? skid_data_reg : a_data;

    assign limit    = (tpb_reg == '0) ? TPB_W'(1) : tpb_reg;
    assign tick_inc = {1'b0, tick_reg} + (TPB_W+1)'(1);
    assign prog_upd = prog_reg + (BLOCK_BITS+1)'(1);

    // read answer, decided from the command in force
    always_comb begin
        rd_sel_array = 1'b0;
        rd_const     = BYTE_ERASED;
        unique case (cmd_reg)
            CMD_READ_ARRAY: rd_sel_array = 1'b1;
            CMD_READ_ID: begin
                if (in_addr == '0)                  rd_const = ID_MANUFACTURER;
                else if (in_addr == ADDR_BITS'(1))  rd_const = ID_DEVICE;
                else                                rd_const = BYTE_ERASED;
            end
            CMD_PROGRAM, CMD_PROGRAM_ALT, CMD_ERASE_SETUP, CMD_READ_STATUS,
            CMD_CLEAR_STAT, CMD_SUSPEND, CMD_CONFIRM: rd_const = status_reg;
            default: rd_const = BYTE_ERASED;
        endcase
    end

    always_comb begin
        status_next  = status_reg;
        cmd_next     = cmd_reg;
        pending_next = pending_reg;
        phase_next   = phase_reg;
        blk_next     = blk_reg;
        prog_next    = prog_reg;
        tick_next    = tick_reg;
        mem_we       = 1'b0;
        mem_wa       = in_addr;
        mem_wd       = s_write_data;

        if (clr_reg) begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = BYTE_POWER_UP;
        end else if (acc) begin
            unique case (s_kind)
                KIND_WRITE: begin
                    if (pending_reg) begin
                        status_next  = (status_reg & ST_SUSPENDED) | ST_READY;
                        pending_next = 1'b0;
                        mem_we       = 1'b1;
                    end else begin
                        cmd_next = s_write_data;
                        unique case (s_write_data)
                            CMD_CLEAR_STAT: status_next = status_reg & ST_SUSPENDED;
                            CMD_PROGRAM, CMD_PROGRAM_ALT: pending_next = 1'b1;
                            CMD_ERASE_SETUP: begin
                                if (phase_reg != PH_ERASING) phase_next = PH_SETUP;
                            end
                            CMD_SUSPEND: begin
                                if ((status_reg & ST_SUSPENDED) == '0) begin
                                    status_next = ST_SUSPENDED | ST_READY;
                                    if (phase_reg == PH_ERASING) begin
                                        phase_next = PH_SUSPENDED;
                                        tick_next  = '0;
                                    end
                                end
                            end
                            CMD_CONFIRM: begin
                                if (phase_reg == PH_SUSPENDED || phase_reg == PH_SETUP) begin
                                    status_next = ST_BUSY;
                                    phase_next  = PH_ERASING;
                                    tick_next   = '0;
                                end
                                // fresh start latches the block and restarts progress
                                if (phase_reg == PH_SETUP) begin
                                    blk_next  = in_addr[ADDR_BITS-1:BLOCK_BITS];
                                    prog_next = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                KIND_TICK: begin
                    if (phase_reg == PH_ERASING) begin
                        if (tick_inc < {1'b0, limit}) begin
                            tick_next = tick_inc[TPB_W-1:0];
                        end else begin
                            tick_next = '0;
                            if (!prog_reg[BLOCK_BITS]) begin
                                mem_we    = 1'b1;
                                mem_wa    = {blk_reg, prog_reg[BLOCK_BITS-1:0]};
                                mem_wd    = BYTE_ERASED;
                                prog_next = prog_upd;
                            end
                            if (prog_reg[BLOCK_BITS] || prog_upd[BLOCK_BITS]) begin
                                status_next = ST_READY;
                                phase_next  = PH_NONE;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (rd_load) mem_rdata_reg <= mem[in_addr];
    end

    always_ff @(posedge aclk) begin
        if (rd_load) begin
            a_sel_array_reg <= rd_sel_array;
            a_const_reg     <= rd_const;
        end
        // older result moves aside when a new read lands on a waiting one
        if (rd_load && a_valid_reg && !(m_fire && !skid_valid_reg)) begin
            skid_data_reg <= a_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpb_reg        <= TPB_RESET;
            status_reg     <= ST_READY;
            cmd_reg        <= CMD_READ_ARRAY;
            pending_reg    <= 1'b0;
            phase_reg      <= PH_NONE;
            blk_reg        <= '0;
            prog_reg       <= '0;
            tick_reg       <= '0;
            clr_reg        <= 1'b1;
            clr_addr_reg   <= '0;
            a_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) tpb_reg <= cfg_data;
            status_reg  <= status_next;
            cmd_reg     <= cmd_next;
            pending_reg <= pending_next;
            phase_reg   <= phase_next;
            blk_reg     <= blk_next;
            prog_reg    <= prog_next;
            tick_reg    <= tick_next;

            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                if (&clr_addr_reg) clr_reg <= 1'b0;
            end

            if (skid_valid_reg) begin
                if (m_fire) skid_valid_reg <= 1'b0;
            end else if (rd_load && a_valid_reg && !m_fire) begin
                skid_valid_reg <= 1'b1;
            end

            if (rd_load) begin
                a_valid_reg <= 1'b1;
            end else if (m_fire && !skid_valid_reg) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/ffcu_checker.sv]
// ----------------------------------------------------------------------------
// ffcu_checker
// Port-level checks for the flash command unit, bound to the top level.
// ----------------------------------------------------------------------------
module ffcu_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [ffcu_pkg::KIND_W-1:0] s_kind,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ffcu_pkg::DATA_W-1:0] m_read_data
);
    import ffcu_pkg::*;

    // the clearing pass keeps the input closed right after reset
    a_reset_closes_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result dropped or changed");

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == KIND_READ |=> m_valid)
        else $error("read transaction produced no result");

    a_no_phantom_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind != KIND_READ && !m_valid |=> !m_valid)
        else $error("result without a read transaction");

endmodule

bind flash_file_memory_command_unit ffcu_checker u_ffcu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_data (m_read_data)
);
